// ===== hdl/b64d_pkg.sv =====
// Shared types, constants and the character lookup of the base64 stream decoder.
package b64d_pkg;

  localparam int unsigned FifoDepth = 4;

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;
  localparam logic [1:0] GroupLast = 2'd3;

  // Bit 6 flags a character outside the alphabet, bits 5:0 hold the sextet.
  typedef logic [6:0] lookup_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
    logic            err;
  } job_t;

  function automatic lookup_t sextet_of(input logic [7:0] c);
    lookup_t r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == PlusChar) begin
      r = {1'b0, 6'd62};
    end else if (c == SlashChar) begin
      r = {1'b0, 6'd63};
    end else if (c == PadChar) begin
      r = 7'h00;
    end
    return r;
  endfunction

endpackage

// ===== hdl/b64d_front.sv =====
// Front end: classifies characters, tracks group state and builds byte jobs.
module b64d_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [7:0]       char_code_i,
  input  logic             message_last_i,
  output logic             push_o,
  output b64d_pkg::job_t   job_o
);

  logic [1:0]  pos_q, pos_d;
  logic [17:0] held_q, held_d;
  logic        tpad_q, tpad_d;
  logic        err_q, err_d;

  b64d_pkg::lookup_t lk;
  logic [5:0]  sx, s0, s1, s2;
  logic        bad, pad, err_now, last_err, grp_end;
  logic [7:0]  b0, b1, b2;

  always_comb begin
    lk       = b64d_pkg::sextet_of(char_code_i);
    bad      = lk[6];
    sx       = bad ? 6'd0 : lk[5:0];
    pad      = (char_code_i == b64d_pkg::PadChar);
    err_now  = err_q | bad;
    grp_end  = (pos_q == b64d_pkg::GroupLast);
    last_err = err_now | !grp_end;
    s0 = held_q[17:12];
    s1 = held_q[11:6];
    s2 = held_q[5:0];
    b0 = {s0, s1[5:4]};
    b1 = {s1[3:0], s2[5:2]};
    b2 = {s2[1:0], sx};

    if (message_last_i && last_err) begin
      job_o.bytes = '0;
      job_o.cnt   = 2'd1;
      job_o.err   = 1'b1;
    end else begin
      job_o.bytes[0] = b0;
      job_o.bytes[1] = tpad_q ? b2 : b1;
      job_o.bytes[2] = b2;
      job_o.cnt      = 2'd1 + 2'(!tpad_q) + 2'(!pad);
      job_o.err      = 1'b0;
    end
    job_o.last = message_last_i;
    push_o = acc_i && ((message_last_i && last_err) || (grp_end && !err_now));

    pos_d  = pos_q;
    held_d = held_q;
    tpad_d = tpad_q;
    err_d  = err_q;
    if (acc_i) begin
      if (message_last_i) begin
        pos_d  = '0;
        held_d = '0;
        tpad_d = 1'b0;
        err_d  = 1'b0;
      end else begin
        pos_d = pos_q + 2'd1;
        err_d = err_now;
        if (grp_end) begin
          held_d = '0;
          tpad_d = 1'b0;
        end else begin
          held_d = {held_q[11:0], sx};
          if (pos_q == 2'd2) begin
            tpad_d = pad;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      held_q <= '0;
      tpad_q <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      held_q <= held_d;
      tpad_q <= tpad_d;
      err_q  <= err_d;
    end
  end

endmodule

// ===== hdl/b64d_fifo.sv =====
// Job queue between the front end and the output sequencer.
module b64d_fifo #(
  parameter int unsigned Depth = b64d_pkg::FifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::job_t wdata_i,
  input  logic           pop_i,
  output b64d_pkg::job_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  b64d_pkg::job_t mem_q [Depth];
  logic [AddrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    full_o  = (cnt_q == CntW'(Depth));
    empty_o = (cnt_q == '0);
    rdata_o = mem_q[rd_q];
    wr_d  = push_i ? ((wr_q == LastAddr) ? '0 : wr_q + AddrW'(1)) : wr_q;
    rd_d  = pop_i ? ((rd_q == LastAddr) ? '0 : rd_q + AddrW'(1)) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/b64d_back.sv =====
// Back end: unpacks each job into result items, one per cycle while the output is not stalled, into an output register.
module b64d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  b64d_pkg::job_t job_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     data_byte_o,
  output logic           byte_valid_o,
  output logic           run_last_o,
  output logic           message_end_o,
  output logic           decode_error_o
);

  b64d_pkg::job_t cur_q, cur_d;
  logic           cur_vld_q, cur_vld_d;
  logic [1:0]     idx_q, idx_d;
  logic           ov_q, ov_d;
  logic [7:0]     data_q, data_d;
  logic           bv_q, bv_d, rl_q, rl_d, me_q, me_d, de_q, de_d;
  logic           adv, fin;

  always_comb begin
    adv   = cur_vld_q && (!ov_q || !out_stall_i);
    fin   = (idx_q == cur_q.cnt - 2'd1);
    pop_o = !empty_i && (!cur_vld_q || (adv && fin));

    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    idx_d     = idx_q;
    if (adv) begin
      idx_d = idx_q + 2'd1;
      if (fin) begin
        cur_vld_d = 1'b0;
      end
    end
    if (pop_o) begin
      cur_d     = job_i;
      cur_vld_d = 1'b1;
      idx_d     = '0;
    end

    ov_d   = ov_q && out_stall_i;
    data_d = data_q;
    bv_d   = bv_q;
    rl_d   = rl_q;
    me_d   = me_q;
    de_d   = de_q;
    if (adv) begin
      ov_d   = 1'b1;
      data_d = cur_q.bytes[idx_q];
      bv_d   = !cur_q.err;
      rl_d   = fin;
      me_d   = fin && cur_q.last;
      de_d   = cur_q.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      idx_q     <= idx_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    data_q <= data_d;
    bv_q   <= bv_d;
    rl_q   <= rl_d;
    me_q   <= me_d;
    de_q   <= de_d;
  end

  assign out_valid_o    = ov_q;
  assign data_byte_o    = data_q;
  assign byte_valid_o   = bv_q;
  assign run_last_o     = rl_q;
  assign message_end_o  = me_q;
  assign decode_error_o = de_q;

endmodule

// ===== hdl/base64_stream_decoder.sv =====
// Top level of the streaming base64 decoder.
// Throughput: one character item per cycle while the queue is not full; the back end emits
// one result item per cycle unless stalled. Results pass the queue, job and output registers.
// A queue of FifoDepth jobs separates the group tracker from the result sequencer.
// Reset is asynchronous and active low; it clears group state, the queue and the output valid flag.
module base64_stream_decoder #(
  parameter int unsigned FifoDepth = b64d_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       message_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       message_end_o,
  output logic       decode_error_o
);

  b64d_pkg::job_t wjob, rjob;
  logic push, pop, full, empty, acc;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  b64d_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (acc),
    .char_code_i    (char_code_i),
    .message_last_i (message_last_i),
    .push_o         (push),
    .job_o          (wjob)
  );

  b64d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wjob),
    .pop_i   (pop),
    .rdata_o (rjob),
    .full_o  (full),
    .empty_o (empty)
  );

  b64d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (rjob),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_o    (data_byte_o),
    .byte_valid_o   (byte_valid_o),
    .run_last_o     (run_last_o),
    .message_end_o  (message_end_o),
    .decode_error_o (decode_error_o)
  );

endmodule

// ===== hdl/b64d_checker.sv =====
// Port-level assertions for the base64 stream decoder and their binding.
module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] char_code_i,
  input logic       message_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] data_byte_o,
  input logic       byte_valid_o,
  input logic       run_last_o,
  input logic       message_end_o,
  input logic       decode_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(byte_valid_o) && $stable(decode_error_o))
    else $error("stalled output item changed");

  a_err_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> !byte_valid_o && data_byte_o == 8'h00
      && run_last_o && message_end_o)
    else $error("malformed error marker");

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> run_last_o)
    else $error("message end without run last");

  a_valid_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !decode_error_o |-> byte_valid_o)
    else $error("non-error item without data");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);
